@@ design/sspq_pkg.sv @@
// Shared types and codes for the stable sorted priority queue.
package sspq_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned DataW       = 32;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned OccW        = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [StatusW-1:0] STATUS_INSERTED  = 2'd0;
  localparam logic [StatusW-1:0] STATUS_REMOVED   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_UNDERFLOW = 2'd2;
  localparam logic [StatusW-1:0] STATUS_FULL      = 2'd3;

  typedef struct packed {
    logic signed [DataW-1:0] item;
    logic signed [DataW-1:0] prio;
  } sspq_entry_t;

  // Operation broadcast to every cell of the chain.
  typedef struct packed {
    logic        ins;
    logic        del;
    sspq_entry_t fresh;
  } sspq_op_t;

endpackage

@@ design/sspq_cell.sv @@
// One storage cell of the sorted shift chain.
module sspq_cell (
  input  logic                 clk_i,
  input  sspq_pkg::sspq_op_t   op_i,
  input  logic                 occupied_i,
  input  logic                 left_le_i,
  input  sspq_pkg::sspq_entry_t left_i,
  input  sspq_pkg::sspq_entry_t right_i,
  output logic                 le_o,
  output sspq_pkg::sspq_entry_t entry_o
);

  sspq_pkg::sspq_entry_t entry_q, entry_d;

  // Cell stays ahead of the new entry when its priority is not larger.
  assign le_o    = occupied_i && (entry_q.prio <= op_i.fresh.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (op_i.ins && !le_o) begin
      // First cell past the run of smaller-or-equal entries takes the new one.
      entry_d = left_le_i ? op_i.fresh : left_i;
    end else if (op_i.del) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

@@ design/stable_sorted_priority_queue_top.sv @@
// Top level of the stable sorted priority queue: a chain of cells kept sorted by priority.
//
// The queue holds up to CAPACITY entries in a row of cells, front entry in the
// first cell. Every cell compares its priority with an incoming one in parallel
// and then either holds, takes the new entry, or takes a neighbor's entry, so
// an insert or a remove updates the whole row at once, and the block accepts
// one beat per cycle whenever the output register is free or being drained.
// The result is registered into the output register when the input beat is
// accepted. Equal priorities leave in arrival order. Removing from an empty
// queue reports underflow with item zero; inserting into a full queue is
// refused with the full status and no change to the contents. Occupancy is
// the count after the operation, truncated to 5 bits.
module stable_sorted_priority_queue_top #(
  parameter int unsigned CAPACITY = sspq_pkg::DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // item_in [31:0], prio_in [63:32]
  input  logic        s_axis_tuser,   // mode [0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // item_out [31:0], occupancy [36:32], zero [39:37]
  output logic [1:0]  m_axis_tuser    // status [1:0]
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);

  logic                          in_fire;
  logic                          is_full, is_empty;
  logic [CountW-1:0]             count_q, count_d;
  logic                          out_valid_q;
  logic [sspq_pkg::DataW-1:0]    out_item_q;
  logic [sspq_pkg::StatusW-1:0]  out_status_q;
  logic [sspq_pkg::OccW-1:0]     out_occ_q;
  logic [sspq_pkg::DataW-1:0]    res_item;
  logic [sspq_pkg::StatusW-1:0]  res_status;
  sspq_pkg::sspq_op_t            op;
  sspq_pkg::sspq_entry_t         entries [CAPACITY];
  logic                          le      [CAPACITY];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign is_full       = (count_q == CountW'(CAPACITY));
  assign is_empty      = (count_q == '0);

  always_comb begin
    op.fresh.item = s_axis_tdata[31:0];
    op.fresh.prio = s_axis_tdata[63:32];
    op.ins        = in_fire && (s_axis_tuser == sspq_pkg::MODE_INSERT) && !is_full;
    op.del        = in_fire && (s_axis_tuser == sspq_pkg::MODE_REMOVE) && !is_empty;
  end

  always_comb begin
    count_d    = count_q;
    res_item   = '0;
    res_status = sspq_pkg::STATUS_INSERTED;
    unique case (s_axis_tuser)
      sspq_pkg::MODE_INSERT: begin
        if (is_full) begin
          res_status = sspq_pkg::STATUS_FULL;
        end else begin
          count_d = count_q + CountW'(1);
        end
      end
      sspq_pkg::MODE_REMOVE: begin
        if (is_empty) begin
          res_status = sspq_pkg::STATUS_UNDERFLOW;
        end else begin
          res_status = sspq_pkg::STATUS_REMOVED;
          res_item   = entries[0].item;
          count_d    = count_q - CountW'(1);
        end
      end
      default: begin
        res_status = sspq_pkg::STATUS_INSERTED;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  occupied;
    logic                  left_le;
    sspq_pkg::sspq_entry_t left_e, right_e;

    assign occupied = (CountW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_le = 1'b1;
      assign left_e  = op.fresh;
    end else begin : g_body
      assign left_le = le[i-1];
      assign left_e  = entries[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = entries[i];
    end else begin : g_mid
      assign right_e = entries[i+1];
    end

    sspq_cell u_cell (
      .clk_i      (clk_i),
      .op_i       (op),
      .occupied_i (occupied),
      .left_le_i  (left_le),
      .left_i     (left_e),
      .right_i    (right_e),
      .le_o       (le[i]),
      .entry_o    (entries[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_item_q   <= res_item;
      out_status_q <= res_status;
      out_occ_q    <= sspq_pkg::OccW'(count_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_occ_q, out_item_q};
  assign m_axis_tuser  = out_status_q;

endmodule
